>>> sv/packet_to_flit_injector_macros.svh
// Assertion macros shared by the packet_to_flit_injector checkers.
// Expects signals named clk and rst in the scope that uses them.
`ifndef PACKET_TO_FLIT_INJECTOR_MACROS_SVH
`define PACKET_TO_FLIT_INJECTOR_MACROS_SVH

// Property checked on every clock edge outside reset.
`define P2F_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("packet_to_flit_injector: check failed");

// Property checked on every clock edge, reset included.
`define P2F_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("packet_to_flit_injector: reset check failed");

`endif

>>> sv/pfi_pkg.sv
// Shared types and constants of the packet-to-flit injector.
// No dependencies; used by pfi_queue and packet_to_flit_injector.
package pfi_pkg;

  localparam int SIZE_W = 7;
  localparam int SEQ_W  = 6;

  localparam logic [SIZE_W-1:0] MAX_PACKET_FLITS = 7'd64;

  // Flit kind codes
  localparam logic [1:0] KIND_HEAD = 2'd0;
  localparam logic [1:0] KIND_BODY = 2'd1;
  localparam logic [1:0] KIND_TAIL = 2'd2;

  // Packet descriptor as held in the queue
  typedef struct packed {
    logic [7:0]        src;
    logic [7:0]        dst;
    logic [31:0]       time_stamp;
    logic [SIZE_W-1:0] size;
  } desc_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> sv/pfi_queue.sv
// Descriptor queue of the packet-to-flit injector: circular buffer with a
// registered head read and write forwarding. Depends on pfi_pkg.
module pfi_queue #(
  parameter int DEPTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  pfi_pkg::q_ctl_t  ctl,
  input  pfi_pkg::desc_t   wr_data,
  output pfi_pkg::q_stat_t stat,
  output pfi_pkg::desc_t   head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  pfi_pkg::desc_t mem [DEPTH];

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_W'(DEPTH));

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    if (ctl.pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (ctl.push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
    end
    case ({ctl.push, ctl.pop})
      2'b10:   count_next = count + CNT_W'(1);
      2'b01:   count_next = count - CNT_W'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Head always tracks the entry at the next read address; a write to that
  // same address in this cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.push && (wr_ptr == rd_ptr_next)) begin
      head <= wr_data;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule

>>> sv/packet_to_flit_injector.sv
// Top level of the packet-to-flit injector: input register, flit sequencing
// and result register. Depends on pfi_pkg and pfi_queue.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction per tick:
//   an optional packet descriptor (push_*) and the receiver's ack_level.
//   Output channel (out_valid / out_stall) returns exactly one transaction
//   per input transaction, in order: an optional flit (flit_*), the
//   request level after the tick and the drop flag for the offered packet.
//   Path: an accepted transaction waits in the input register, is processed
//   into the result register and is taken from there.
//   Throughput: one transaction per cycle while out_stall is low. The whole
//   tick (queue push, head select, flit kind/sequence, pop) is one pass of
//   logic between the input register and the result register; the queue
//   head is read ahead from its memory so it is ready in the same pass.
//   Stall: while out_stall holds a waiting result, one more transaction can
//   sit in the input register; after that in_stall rises.
//   Reset (rst, synchronous): the queue is emptied, flits_left and tx_level
//   (the request level) go to zero, both channels go idle. Queue storage is not
//   cleared; entries are only read after they have been written.
module packet_to_flit_injector #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        push_valid,
  input  logic [7:0]  push_src,
  input  logic [7:0]  push_dst,
  input  logic [31:0] push_time,
  input  logic [6:0]  push_size,
  input  logic        ack_level,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        flit_valid,
  output logic [7:0]  flit_src,
  output logic [7:0]  flit_dst,
  output logic [31:0] flit_time,
  output logic [5:0]  flit_seq,
  output logic [6:0]  flit_length,
  output logic [1:0]  flit_kind,
  output logic        req_level,
  output logic        push_dropped
);

  // Input register
  logic           a_valid;
  logic           a_push_valid;
  logic           a_ack;
  pfi_pkg::desc_t a_desc;

  // Sequencing state
  logic [pfi_pkg::SIZE_W-1:0] flits_left;
  logic [pfi_pkg::SIZE_W-1:0] flits_left_next;
  logic                       tx_level;

  // Processing signals
  logic                       adv;
  logic                       push_ok;
  logic                       send_ok;
  logic                       dropped;
  pfi_pkg::desc_t             push_desc;
  pfi_pkg::desc_t             head;
  pfi_pkg::desc_t             q_head;
  pfi_pkg::q_ctl_t            q_ctl;
  pfi_pkg::q_stat_t           q_stat;
  logic [pfi_pkg::SIZE_W-1:0] fl_cur;
  logic [1:0]                 kind;
  logic [pfi_pkg::SEQ_W-1:0]  seq;

  // A transaction moves on when the result register is free or being taken.
  assign adv      = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      a_valid <= 1'b1;
    end else if (adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_push_valid      <= push_valid;
      a_ack             <= ack_level;
      a_desc.src        <= push_src;
      a_desc.dst        <= push_dst;
      a_desc.time_stamp <= push_time;
      a_desc.size       <= push_size;
    end
  end

  // Offered descriptor with its size clamped to 1..MAX_PACKET_FLITS
  always_comb begin
    push_desc = a_desc;
    if (a_desc.size == '0) begin
      push_desc.size = pfi_pkg::SIZE_W'(1);
    end else if (a_desc.size > pfi_pkg::MAX_PACKET_FLITS) begin
      push_desc.size = pfi_pkg::MAX_PACKET_FLITS;
    end
  end

  pfi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl     (q_ctl),
    .wr_data (push_desc),
    .stat    (q_stat),
    .head    (q_head)
  );

  always_comb begin
    dropped = a_push_valid && q_stat.full;
    push_ok = a_push_valid && !q_stat.full;
    // an empty queue gets its head from this tick's push
    send_ok = (a_ack == tx_level) && (!q_stat.empty || push_ok);
    head    = q_stat.empty ? push_desc : q_head;

    // zero flits_left means the head packet has not started
    if ((flits_left == '0) || (flits_left > head.size)) begin
      fl_cur = head.size;
    end else begin
      fl_cur = flits_left;
    end

    if (fl_cur == head.size) begin
      kind = pfi_pkg::KIND_HEAD;
    end else if (fl_cur == pfi_pkg::SIZE_W'(1)) begin
      kind = pfi_pkg::KIND_TAIL;
    end else begin
      kind = pfi_pkg::KIND_BODY;
    end

    seq             = pfi_pkg::SEQ_W'(head.size - fl_cur);
    flits_left_next = send_ok ? fl_cur - pfi_pkg::SIZE_W'(1) : flits_left;

    q_ctl.push = adv && push_ok;
    q_ctl.pop  = adv && send_ok && (fl_cur == pfi_pkg::SIZE_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flits_left <= '0;
      tx_level   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (adv) begin
        flits_left <= flits_left_next;
        tx_level   <= tx_level ^ send_ok;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register; flit fields read zero when no flit goes out.
  always_ff @(posedge clk) begin
    if (adv) begin
      flit_valid   <= send_ok;
      flit_src     <= send_ok ? head.src : '0;
      flit_dst     <= send_ok ? head.dst : '0;
      flit_time    <= send_ok ? head.time_stamp : '0;
      flit_seq     <= send_ok ? seq : '0;
      flit_length  <= send_ok ? head.size : '0;
      flit_kind    <= send_ok ? kind : pfi_pkg::KIND_HEAD;
      req_level    <= tx_level ^ send_ok;
      push_dropped <= dropped;
    end
  end

endmodule

>>> sv/packet_to_flit_injector_chk.sv
// Port-level checker for packet_to_flit_injector, bound to the top level.
// Depends on packet_to_flit_injector_macros.svh.
`include "packet_to_flit_injector_macros.svh"

module packet_to_flit_injector_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        flit_valid,
  input logic [7:0]  flit_src,
  input logic [7:0]  flit_dst,
  input logic [31:0] flit_time,
  input logic [5:0]  flit_seq,
  input logic [6:0]  flit_length,
  input logic [1:0]  flit_kind
);

  // A held result keeps its flit.
  `P2F_CHECK(a_hold, out_valid && out_stall |=> out_valid && $stable(flit_valid) && $stable(flit_seq) && $stable(flit_kind) && $stable(flit_time))

  // No flit: all flit fields zero.
  `P2F_CHECK(a_idle_zero, out_valid && !flit_valid |-> flit_src == 8'd0 && flit_dst == 8'd0 && flit_time == 32'd0 && flit_seq == 6'd0 && flit_length == 7'd0 && flit_kind == 2'd0)

  // Head flit exactly when the sequence number is zero; seq stays below length.
  `P2F_CHECK(a_seq_head, out_valid && flit_valid |-> ((flit_kind == 2'd0) == (flit_seq == 6'd0)) && ({1'b0, flit_seq} < flit_length))

  // Tail flit is the last one of its packet.
  `P2F_CHECK(a_seq_tail, out_valid && flit_valid && flit_kind == 2'd2 |-> {1'b0, flit_seq} + 7'd1 == flit_length)

  // Both channels come out of reset idle.
  `P2F_CHECK_ALWAYS(a_reset_idle, $past(rst) |-> !out_valid && !in_stall)

endmodule

bind packet_to_flit_injector packet_to_flit_injector_chk u_chk (.*);
